/* hw/rtl/lwc_pkg.sv */
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared constants, types and blend arithmetic of the window compositor.
// ----------------------------------------------------------------------------
package lwc_pkg;

   localparam int MAX_SLOTS   = 32;
   localparam int SCREEN_COLS = 1920;
   localparam int SCREEN_ROWS = 1080;

   localparam int SLOT_W   = 5;
   localparam int COORD_W  = 11;
   localparam int POS_W    = 13;
   localparam int DX_W     = POS_W + 1;
   localparam int SIZE_W   = 12;
   localparam int COLOR_W  = 24;
   localparam int CH_W     = 8;
   localparam int ALPHA_W  = 8;
   localparam int SUM_W    = 16;
   localparam int ACTIVE_W = 6;
   localparam int SCR_W    = 13;

   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ACCENT     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE     = 2'd2;

   localparam logic [COLOR_W-1:0]  RESET_BACKGROUND = 24'h121212;
   localparam logic [COLOR_W-1:0]  RESET_ACCENT     = 24'h0078D7;
   localparam logic [ACTIVE_W-1:0] RESET_ACTIVE     = '0;

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

   typedef struct packed {
      logic signed [POS_W-1:0] left;
      logic signed [POS_W-1:0] top;
      logic [SIZE_W-1:0]       width;
      logic [SIZE_W-1:0]       height;
      logic [COLOR_W-1:0]      color;
      logic [ALPHA_W-1:0]      alpha;
      logic                    visible;
      logic                    focused;
   } lwc_window_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  background;
      logic [COLOR_W-1:0]  accent;
      logic [ACTIVE_W-1:0] active;
   } lwc_cfg_type;

   typedef struct packed {
      logic               valid;
      logic               onscreen;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] color;
   } lwc_link_type;

   typedef struct packed {
      logic               valid;
      logic               onscreen;
      logic               hit;
      logic               border;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] color;
      logic [SUM_W-1:0]   sum_r;
      logic [SUM_W-1:0]   sum_g;
      logic [SUM_W-1:0]   sum_b;
   } lwc_mid_type;

   function automatic logic [SUM_W-1:0] blend_sum(
      input logic [CH_W-1:0]    fg,
      input logic [CH_W-1:0]    bg,
      input logic [ALPHA_W-1:0] a
   );
      logic [SUM_W-1:0] p_fg;
      logic [SUM_W-1:0] p_bg;
      p_fg = SUM_W'(fg) * SUM_W'(a);
      p_bg = SUM_W'(bg) * SUM_W'(ALPHA_FULL - a);
      return SUM_W'(p_fg + p_bg);
   endfunction

   // exact floor(s / 255) for s below 65280
   function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] s);
      logic [SUM_W:0] t;
      t = (SUM_W+1)'(s) + (SUM_W+1)'(s >> CH_W) + (SUM_W+1)'(1);
      return t[SUM_W-1:CH_W];
   endfunction

endpackage

/* hw/rtl/lwc_csr.sv */
// ----------------------------------------------------------------------------
// lwc_csr
// Configuration registers behind the register bus: background, accent, count.
// ----------------------------------------------------------------------------
module lwc_csr import lwc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output lwc_cfg_type       cfg
);

   logic [COLOR_W-1:0]   background_ff;
   logic [COLOR_W-1:0]   accent_ff;
   logic [ACTIVE_W-1:0]  active_ff;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         background_ff <= RESET_BACKGROUND;
         accent_ff     <= RESET_ACCENT;
         active_ff     <= RESET_ACTIVE;
      end else if (wr_en) begin
         case (idx)
            REG_BACKGROUND: background_ff <= pwdata[COLOR_W-1:0];
            REG_ACCENT:     accent_ff     <= pwdata[COLOR_W-1:0];
            REG_ACTIVE:     active_ff     <= pwdata[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_BACKGROUND: prdata = DATA_W'(background_ff);
         REG_ACCENT:     prdata = DATA_W'(accent_ff);
         REG_ACTIVE:     prdata = DATA_W'(active_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.background = background_ff;
   assign cfg.accent     = accent_ff;
   assign cfg.active     = active_ff;

endmodule

/* hw/rtl/lwc_cell.sv */
// ----------------------------------------------------------------------------
// lwc_cell
// One window slot: holds its rectangle and look, and composites the passing
// pixel over two stages (cover test and products, then divide and select).
// ----------------------------------------------------------------------------
module lwc_cell import lwc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               active,
   input  logic               wr_en,
   input  lwc_window_type     wr_win,
   input  logic [COLOR_W-1:0] accent,
   input  lwc_link_type       link_in,
   output lwc_link_type       link_out,
   output logic               busy
);

   lwc_window_type     win_ff;
   lwc_mid_type        mid_ff;
   lwc_mid_type        mid_in;
   lwc_link_type       out_ff;
   lwc_link_type       out_in;
   logic [DX_W-1:0]    dx;
   logic [DX_W-1:0]    dy;
   logic               in_x;
   logic               in_y;
   logic               bord_x;
   logic               bord_y;
   logic [COLOR_W-1:0] blended;

   always_comb begin
      dx = DX_W'(link_in.col) - {win_ff.left[POS_W-1], win_ff.left};
      dy = DX_W'(link_in.row) - {win_ff.top[POS_W-1], win_ff.top};

      in_x = !dx[DX_W-1] && (dx[POS_W-1:0] < POS_W'(win_ff.width));
      in_y = !dy[DX_W-1] && (dy[POS_W-1:0] < POS_W'(win_ff.height));

      bord_x = (dx[POS_W-1:0] < POS_W'(2)) ||
               (DX_W'(dx[POS_W-1:0]) + DX_W'(2) >= DX_W'(win_ff.width));
      bord_y = (dy[POS_W-1:0] < POS_W'(2)) ||
               (DX_W'(dy[POS_W-1:0]) + DX_W'(2) >= DX_W'(win_ff.height));

      mid_in.valid    = link_in.valid;
      mid_in.onscreen = link_in.onscreen;
      mid_in.hit      = active && win_ff.visible && link_in.onscreen && in_x && in_y;
      mid_in.border   = win_ff.focused && (bord_x || bord_y);
      mid_in.col      = link_in.col;
      mid_in.row      = link_in.row;
      mid_in.color    = link_in.color;
      mid_in.sum_r    = blend_sum(win_ff.color[23:16], link_in.color[23:16], win_ff.alpha);
      mid_in.sum_g    = blend_sum(win_ff.color[15:8], link_in.color[15:8], win_ff.alpha);
      mid_in.sum_b    = blend_sum(win_ff.color[7:0], link_in.color[7:0], win_ff.alpha);
   end

   always_comb begin
      blended = {div255(mid_ff.sum_r), div255(mid_ff.sum_g), div255(mid_ff.sum_b)};

      out_in.valid    = mid_ff.valid;
      out_in.onscreen = mid_ff.onscreen;
      out_in.col      = mid_ff.col;
      out_in.row      = mid_ff.row;
      if (!mid_ff.hit) begin
         out_in.color = mid_ff.color;
      end else if (mid_ff.border) begin
         out_in.color = accent;
      end else begin
         out_in.color = blended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (wr_en) begin
         win_ff <= wr_win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
      end
   end

   assign link_out = out_ff;
   assign busy     = mid_ff.valid || out_ff.valid;

endmodule

/* hw/rtl/layered_window_pixel_compositor_top.sv */
// ----------------------------------------------------------------------------
// layered_window_pixel_compositor_top
// Window table compositor: slot writes and RGB888 pixel queries.
// ----------------------------------------------------------------------------
// Pixel queries are taken one per clock while the result output is not
// stalled, and are answered in order: each slot is a cell in a chain,
// and every cell spends two pipeline stages on the pixel passing through it.
// A slot write is registered into its cell when it is taken, but is taken
// only when no pixel is in the chain, so after a query it waits for the
// chain to drain. A stalled result output holds the whole chain.
// ----------------------------------------------------------------------------
module layered_window_pixel_compositor_top import lwc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [SLOT_W-1:0]         req_slot,
   input  logic signed [POS_W-1:0]   req_win_left,
   input  logic signed [POS_W-1:0]   req_win_top,
   input  logic [SIZE_W-1:0]         req_win_width,
   input  logic [SIZE_W-1:0]         req_win_height,
   input  logic [COLOR_W-1:0]        req_win_color,
   input  logic [ALPHA_W-1:0]        req_win_alpha,
   input  logic                      req_win_visible,
   input  logic                      req_win_focused,
   input  logic [COORD_W-1:0]        req_pixel_col,
   input  logic [COORD_W-1:0]        req_pixel_row,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COLOR_W-1:0]        rsp_pixel_color,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   lwc_cfg_type            cfg;
   lwc_window_type         wr_win;
   lwc_link_type           link [0:MAX_SLOTS];
   logic [MAX_SLOTS-1:0]   cell_busy;
   logic                   chain_busy;
   logic                   adv;
   logic                   px_accept;
   logic                   wr_accept;
   logic                   rsp_valid_ff;
   logic [COLOR_W-1:0]     rsp_pixel_color_ff;

   lwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign adv        = !rsp_valid_ff || rsp_ready;
   assign chain_busy = |cell_busy;
   assign req_ready  = req_type ? adv : !chain_busy;
   assign px_accept  = req_valid && req_ready && req_type;
   assign wr_accept  = req_valid && req_ready && !req_type;

   always_comb begin
      wr_win.left    = req_win_left;
      wr_win.top     = req_win_top;
      wr_win.width   = req_win_width;
      wr_win.height  = req_win_height;
      wr_win.color   = req_win_color;
      wr_win.alpha   = req_win_alpha;
      wr_win.visible = req_win_visible;
      wr_win.focused = req_win_focused;

      link[0].valid    = px_accept;
      link[0].onscreen = (SCR_W'(req_pixel_col) < SCR_W'(SCREEN_COLS)) &&
                         (SCR_W'(req_pixel_row) < SCR_W'(SCREEN_ROWS));
      link[0].col      = req_pixel_col;
      link[0].row      = req_pixel_row;
      link[0].color    = cfg.background;
   end

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      lwc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .active   (cfg.active > ACTIVE_W'(i)),
         .wr_en    (wr_accept && (ACTIVE_W'(req_slot) == ACTIVE_W'(i))),
         .wr_win   (wr_win),
         .accent   (cfg.accent),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .busy     (cell_busy[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= link[MAX_SLOTS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pixel_color_ff <= link[MAX_SLOTS].color;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_pixel_color_ff;

   a_write_on_empty: assert property (@(posedge clock) disable iff (reset)
      wr_accept |-> !chain_busy)
      else $error("slot write taken while a pixel is in the chain");

   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cell_busy))
      else $error("chain moved during output stall");

   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      px_accept |=> cell_busy[0])
      else $error("accepted pixel missing from first cell");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !chain_busy && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared from an empty chain");

endmodule

/* bench/layered_window_pixel_compositor_top_tb.sv */
// ----------------------------------------------------------------------------
// layered_window_pixel_compositor_top_tb
// Self-checking bench for the layered window pixel compositor.
// ----------------------------------------------------------------------------
// Slot writes and pixel queries go in through a valid/ready driver, and
// composited colors are checked in order against a shadow window table kept
// in the bench. Background, accent and layer count are changed over the APB
// port between phases, while the pipeline is empty. Both sides idle at
// random, and at one point the result side holds off long enough to back up
// the whole chain.
// ----------------------------------------------------------------------------
module layered_window_pixel_compositor_top_tb import lwc_pkg::*; ;

   typedef enum logic {
      SLOT_WRITE  = 1'b0,
      PIXEL_QUERY = 1'b1
   } request_kind_type;

   typedef struct {
      request_kind_type        kind;
      logic [SLOT_W-1:0]       slot;
      logic signed [POS_W-1:0] left;
      logic signed [POS_W-1:0] top;
      logic [SIZE_W-1:0]       width;
      logic [SIZE_W-1:0]       height;
      logic [COLOR_W-1:0]      color;
      logic [ALPHA_W-1:0]      alpha;
      logic                    visible;
      logic                    focused;
      logic [COORD_W-1:0]      col;
      logic [COORD_W-1:0]      row;
   } screen_request_type;

   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int CHAIN_LATENCY     = 2*MAX_SLOTS + 1;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int PHASES            = 8;
   localparam int PHASE_ITEMS       = 250;
   localparam int MAX_PIXEL         = 2047;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = 1'b0;
   logic [SLOT_W-1:0]       req_slot = '0;
   logic signed [POS_W-1:0] req_win_left = '0;
   logic signed [POS_W-1:0] req_win_top = '0;
   logic [SIZE_W-1:0]       req_win_width = '0;
   logic [SIZE_W-1:0]       req_win_height = '0;
   logic [COLOR_W-1:0]      req_win_color = '0;
   logic [ALPHA_W-1:0]      req_win_alpha = '0;
   logic                    req_win_visible = 1'b0;
   logic                    req_win_focused = 1'b0;
   logic [COORD_W-1:0]      req_pixel_col = '0;
   logic [COORD_W-1:0]      req_pixel_row = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [COLOR_W-1:0]      rsp_pixel_color;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_W-1:0]       paddr = '0;
   logic [DATA_W-1:0]       pwdata = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   // shadow of the block
   lwc_window_type     window_table [MAX_SLOTS];
   logic [COLOR_W-1:0] bg_shadow = RESET_BACKGROUND;
   logic [COLOR_W-1:0] accent_shadow = RESET_ACCENT;
   logic [ACTIVE_W-1:0] active_shadow = RESET_ACTIVE;

   // window placement as the stimulus will leave it, for aiming queries
   int plan_left [MAX_SLOTS];
   int plan_top [MAX_SLOTS];
   int plan_width [MAX_SLOTS];
   int plan_height [MAX_SLOTS];

   screen_request_type pending_requests[$];
   screen_request_type on_wire;
   logic [COLOR_W-1:0] expected_colors[$];
   logic [COLOR_W-1:0] want_color;

   int send_mode = 0;
   int recv_mode = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int long_stall_left = 0;
   bit long_stall_req = 1'b0;
   int idle_cycles = 0;
   int n_errors = 0;
   int n_queries = 0;
   int n_writes = 0;
   int n_results = 0;
   int n_settings = 0;
   int phase;

   layered_window_pixel_compositor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_win_left    (req_win_left),
      .req_win_top     (req_win_top),
      .req_win_width   (req_win_width),
      .req_win_height  (req_win_height),
      .req_win_color   (req_win_color),
      .req_win_alpha   (req_win_alpha),
      .req_win_visible (req_win_visible),
      .req_win_focused (req_win_focused),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [CH_W-1:0] blend_channel(input int fg, input int bg, input int a);
      return CH_W'((fg * a + bg * (int'(ALPHA_FULL) - a)) / int'(ALPHA_FULL));
   endfunction

   function automatic logic [COLOR_W-1:0] composite_pixel(input logic [COORD_W-1:0] col,
                                                          input logic [COORD_W-1:0] row);
      logic [COLOR_W-1:0] pix;
      lwc_window_type w;
      int layers;
      int dx;
      int dy;
      pix = bg_shadow;
      layers = (active_shadow > MAX_SLOTS) ? MAX_SLOTS : int'(active_shadow);
      if (col >= SCREEN_COLS || row >= SCREEN_ROWS)
         return pix;
      for (int i = 0; i < layers; i++) begin
         w = window_table[i];
         dx = int'(col) - int'($signed(w.left));
         dy = int'(row) - int'($signed(w.top));
         if (!w.visible || dx < 0 || dy < 0)
            continue;
         if (dx >= int'(w.width) || dy >= int'(w.height))
            continue;
         if (w.alpha == ALPHA_FULL) begin
            pix = w.color;
         end else begin
            pix = {blend_channel(w.color[23:16], pix[23:16], w.alpha),
                   blend_channel(w.color[15:8], pix[15:8], w.alpha),
                   blend_channel(w.color[7:0], pix[7:0], w.alpha)};
         end
         if (w.focused && (dx < 2 || dx + 2 >= int'(w.width) ||
                           dy < 2 || dy + 2 >= int'(w.height)))
            pix = accent_shadow;
      end
      return pix;
   endfunction

   task automatic apply_request(input screen_request_type r);
      if (r.kind == SLOT_WRITE) begin
         window_table[r.slot].left    = r.left;
         window_table[r.slot].top     = r.top;
         window_table[r.slot].width   = r.width;
         window_table[r.slot].height  = r.height;
         window_table[r.slot].color   = r.color;
         window_table[r.slot].alpha   = r.alpha;
         window_table[r.slot].visible = r.visible;
         window_table[r.slot].focused = r.focused;
         n_writes++;
      end else begin
         expected_colors.push_back(composite_pixel(r.col, r.row));
         n_queries++;
      end
   endtask

   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   function automatic screen_request_type junk_request();
      screen_request_type r;
      r.kind    = PIXEL_QUERY;
      r.slot    = SLOT_W'($urandom);
      r.left    = POS_W'($urandom);
      r.top     = POS_W'($urandom);
      r.width   = SIZE_W'($urandom);
      r.height  = SIZE_W'($urandom);
      r.color   = COLOR_W'($urandom);
      r.alpha   = ALPHA_W'($urandom);
      r.visible = 1'($urandom);
      r.focused = 1'($urandom);
      r.col     = COORD_W'($urandom);
      r.row     = COORD_W'($urandom);
      return r;
   endfunction

   task automatic queue_slot_write(input int slot, input int left, input int top,
                                   input int width, input int height,
                                   input logic [COLOR_W-1:0] color, input int alpha,
                                   input bit visible, input bit focused);
      screen_request_type r;
      r = junk_request();
      r.kind    = SLOT_WRITE;
      r.slot    = SLOT_W'(slot);
      r.left    = POS_W'(left);
      r.top     = POS_W'(top);
      r.width   = SIZE_W'(width);
      r.height  = SIZE_W'(height);
      r.color   = color;
      r.alpha   = ALPHA_W'(alpha);
      r.visible = visible;
      r.focused = focused;
      pending_requests.push_back(r);
      plan_left[slot]   = left;
      plan_top[slot]    = top;
      plan_width[slot]  = width;
      plan_height[slot] = height;
   endtask

   task automatic queue_pixel_query(input int col, input int row);
      screen_request_type r;
      r = junk_request();
      r.kind = PIXEL_QUERY;
      r.col  = COORD_W'(col);
      r.row  = COORD_W'(row);
      pending_requests.push_back(r);
   endtask

   function automatic int slot_limit();
      if (active_shadow == 0)
         return MAX_SLOTS - 1;
      return ((active_shadow > MAX_SLOTS) ? MAX_SLOTS : int'(active_shadow)) - 1;
   endfunction

   task automatic queue_random_write();
      int slot;
      int left;
      int top;
      int width;
      int height;
      int alpha;
      int pick;
      slot = ($urandom_range(0, 3) != 0) ? $urandom_range(0, slot_limit())
                                         : $urandom_range(0, MAX_SLOTS - 1);
      if ($urandom_range(0, 9) == 0) begin
         left = int'($urandom_range(0, 8191)) - 4096;
         top  = int'($urandom_range(0, 8191)) - 4096;
      end else begin
         left = int'($urandom_range(0, 2100)) - 150;
         top  = int'($urandom_range(0, 1250)) - 150;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         width  = $urandom_range(0, 4095);
         height = $urandom_range(0, 4095);
      end else if (pick < 3) begin
         width  = $urandom_range(0, 4);
         height = $urandom_range(0, 4);
      end else begin
         width  = $urandom_range(1, 400);
         height = $urandom_range(1, 400);
      end
      pick = $urandom_range(0, 9);
      alpha = (pick < 3) ? 255 : (pick == 3) ? 0 : $urandom_range(0, 255);
      queue_slot_write(slot, left, top, width, height, COLOR_W'($urandom), alpha,
                       $urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0);
   endtask

   task automatic queue_random_query();
      int slot;
      int col;
      int row;
      if ($urandom_range(0, 9) == 0) begin
         queue_pixel_query($urandom_range(0, MAX_PIXEL), $urandom_range(0, MAX_PIXEL));
      end else begin
         slot = $urandom_range(0, slot_limit());
         col = plan_left[slot] - 3 + int'($urandom_range(0, plan_width[slot] + 5));
         row = plan_top[slot] - 3 + int'($urandom_range(0, plan_height[slot] + 5));
         if (col < 0 || col > MAX_PIXEL)
            col = $urandom_range(0, SCREEN_COLS - 1);
         if (row < 0 || row > MAX_PIXEL)
            row = $urandom_range(0, SCREEN_ROWS - 1);
         queue_pixel_query(col, row);
      end
   endtask

   task automatic queue_directed_items();
      queue_slot_write(0, -4096, -4096, 4095, 4095, 24'hFFFFFF, 255, 1'b1, 1'b0);
      queue_slot_write(1, 0, 0, SCREEN_COLS, SCREEN_ROWS, 24'h00FF80, 255, 1'b1, 1'b1);
      queue_slot_write(2, 100, 50, 0, 10, 24'hABCDEF, 255, 1'b1, 1'b1);
      queue_slot_write(3, 4095, 4095, 4095, 4095, 24'h123456, 255, 1'b1, 1'b1);
      queue_slot_write(4, 10, 10, 2, 1, 24'hF0F0F0, 128, 1'b1, 1'b1);
      queue_slot_write(5, 20, 20, 3, 3, 24'h0F0F0F, 200, 1'b1, 1'b1);
      queue_slot_write(30, 500, 500, 50, 50, 24'h00FF00, 1, 1'b0, 1'b0);
      queue_slot_write(31, 500, 500, 100, 100, 24'hFFFFFF, 0, 1'b1, 1'b0);
      queue_pixel_query(0, 0);
      queue_pixel_query(SCREEN_COLS - 1, SCREEN_ROWS - 1);
      queue_pixel_query(SCREEN_COLS, 0);
      queue_pixel_query(0, SCREEN_ROWS);
      queue_pixel_query(MAX_PIXEL, MAX_PIXEL);
      queue_pixel_query(10, 10);
      queue_pixel_query(11, 10);
      queue_pixel_query(2, 2);
      queue_pixel_query(1, 500);
      queue_pixel_query(SCREEN_COLS - 2, 500);
      queue_pixel_query(520, 520);
      queue_pixel_query(21, 21);
      queue_pixel_query(600, 600);
      queue_pixel_query(599, 599);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_BACKGROUND: bg_shadow = value[COLOR_W-1:0];
         REG_ACCENT:     accent_shadow = value[COLOR_W-1:0];
         REG_ACTIVE:     active_shadow = value[ACTIVE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] accent,
                            input logic [ACTIVE_W-1:0] active);
      csr_write(REG_BACKGROUND, {8'($urandom), bg});
      csr_write(REG_ACCENT, {8'($urandom), accent});
      csr_write(REG_ACTIVE, {26'($urandom), active});
      csr_write(REG_UNUSED, $urandom);
      n_settings++;
   endtask

   // hold until the chain has drained
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      repeat (CHAIN_LATENCY + 8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            apply_request(on_wire);
         if (!req_valid || req_ready) begin
            if (send_gap > 0 && long_stall_left == 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               on_wire = pending_requests.pop_front();
               req_type        <= on_wire.kind;
               req_slot        <= on_wire.slot;
               req_win_left    <= on_wire.left;
               req_win_top     <= on_wire.top;
               req_win_width   <= on_wire.width;
               req_win_height  <= on_wire.height;
               req_win_color   <= on_wire.color;
               req_win_alpha   <= on_wire.alpha;
               req_win_visible <= on_wire.visible;
               req_win_focused <= on_wire.focused;
               req_pixel_col   <= on_wire.col;
               req_pixel_row   <= on_wire.row;
               req_valid       <= 1'b1;
               send_gap = draw_gap(send_mode);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
         long_stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected pixel result, expected none, actual %06h",
                        $time, rsp_pixel_color);
               n_errors++;
            end else begin
               want_color = expected_colors.pop_front();
               if (rsp_pixel_color !== want_color) begin
                  $display("%0t: pixel_color mismatch, expected %06h, actual %06h",
                           $time, want_color, rsp_pixel_color);
                  n_errors++;
               end
            end
            recv_gap = draw_gap(recv_mode);
         end
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            long_stall_left = LONG_STALL_CYCLES;
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("[layered_window_pixel_compositor_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         window_table[i] = '0;
         plan_left[i] = 0;
         plan_top[i] = 0;
         plan_width[i] = 0;
         plan_height[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: nothing composited yet
      queue_pixel_query(0, 0);
      queue_pixel_query(SCREEN_COLS / 2, SCREEN_ROWS / 2);
      wait_idle();
      configure(24'h203040, 24'hFFFF00, 6'd32);
      queue_directed_items();

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: configure(24'h000000, 24'hFFFFFF, 6'd32);
            1: configure(24'hFFFFFF, 24'h000000, 6'd63);
            2: configure(COLOR_W'($urandom), COLOR_W'($urandom), 6'd32);
            3: configure(COLOR_W'($urandom), COLOR_W'($urandom), 6'd0);
            4: configure(COLOR_W'($urandom), COLOR_W'($urandom), 6'd1);
            5: configure(COLOR_W'($urandom), COLOR_W'($urandom), 6'd33);
            6: configure(COLOR_W'($urandom), COLOR_W'($urandom), 6'd8);
            default: configure(COLOR_W'($urandom), COLOR_W'($urandom),
                               ACTIVE_W'($urandom_range(0, 63)));
         endcase
         send_mode = phase % 3;
         recv_mode = (phase + 1) % 3;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 25)
               queue_random_write();
            else
               queue_random_query();
         end
         if (phase == 2)
            long_stall_req = 1'b1;
      end

      wait_idle();
      $display("Checked %0d pixel queries (%0d results) and %0d slot writes",
               n_queries, n_results, n_writes);
      $display("across %0d register settings, %0d mismatches", n_settings, n_errors);
      if (n_errors == 0)
         $display("[layered_window_pixel_compositor_top] OK");
      else
         $display("[layered_window_pixel_compositor_top] ERROR");
      $finish;
   end

endmodule
